// ===== src/mts_pkg.sv =====
package mts_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  localparam int TIME_W = 64;
  localparam int PRICE_W = 48;
  localparam int THR_W = 20;
  localparam int QTY_W = 32;
  localparam int LOOK_W = 40;
  localparam int ID_W = 32;

  // dividend |mid - ref| * 10000 fits in 62 bits, sign kept separately
  localparam int DIV_W = 62;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam logic [13:0] BPS_SCALE = 14'd10000;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_QUANTITY = 2'd1;
  localparam logic [1:0] REG_LOOKBACK = 2'd2;

  localparam logic CMD_BOOK = 1'b0;
  localparam logic CMD_TRADE = 1'b1;

  localparam logic SIDE_BUY = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // request to the divider and its result
  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [PRICE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/momentum_threshold_signal_top.sv =====
// momentum threshold signal over a timestamped price ring
// an evaluated update reads n entries in the ring walk (at most 64, each through
// S_READ then S_WALK), then runs 62 divider steps in S_DIV before any order
// throughput: one word at a time; ignored, held and first-sample words leave input ready,
// an evaluated word blocks input until the divide ends and any order it made is taken
// reset: synchronous, active high; ring contents undefined, counters clear, next id one
module momentum_threshold_signal_top import mts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command, flat flag
  input  logic [1:0]  s_tuser,
  // tick time [63:0], book mid [111:64]
  input  logic [111:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // order side
  output logic        m_tuser,
  // quantity [31:0], order number [63:32]
  output logic [63:0] m_tdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WALK, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [THR_W-1:0] sig_threshold;
  logic [QTY_W-1:0] order_quantity;
  logic [LOOK_W-1:0] lookback_ticks;

  logic [PTR_W-1:0] write_pointer;
  logic [CNT_W-1:0] sample_count;
  logic position_held;
  logic [ID_W-1:0] next_identifier;

  logic [PRICE_W-1:0] mid;
  logic [PRICE_W-1:0] best;
  logic [TIME_W-1:0] oldest;
  logic [CNT_W-1:0] walk_i;
  logic [PTR_W-1:0] raddr;
  logic [TIME_W-1:0] rd_time;
  logic [PRICE_W-1:0] rd_price;
  logic neg;
  logic dreq_start;
  div_req_t dreq;
  div_rsp_t drsp;

  logic in_acc;
  logic [TIME_W-1:0] in_time;
  logic [PRICE_W-1:0] in_price;
  logic ring_we;

  assign in_acc = s_tvalid && s_tready;
  assign in_time = s_tdata[63:0];
  assign in_price = s_tdata[111:64];
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign ring_we = in_acc && (s_tuser[0] == CMD_BOOK) && (in_price != '0)
                   && !in_price[PRICE_W-1];

  mts_ram #(.WIDTH(TIME_W), .DEPTH(RING_DEPTH)) u_times (
    .clk(clk), .we(ring_we), .waddr(write_pointer), .wdata(in_time),
    .raddr(raddr), .rdata(rd_time)
  );

  mts_ram #(.WIDTH(PRICE_W), .DEPTH(RING_DEPTH)) u_prices (
    .clk(clk), .we(ring_we), .waddr(write_pointer), .wdata(in_price),
    .raddr(raddr), .rdata(rd_price)
  );

  mts_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // walk address: newest minus walk_i
  assign raddr = write_pointer - PTR_W'(1) - walk_i[PTR_W-1:0];

  // change magnitude and comparison
  logic [PRICE_W-1:0] diff_mag;
  logic [DIV_W-1:0] scaled;
  logic [DIV_W:0] thr_ext;
  logic over;
  always_comb begin
    if (mid >= best) begin
      diff_mag = mid - best;
    end else begin
      diff_mag = best - mid;
    end
    scaled = DIV_W'(diff_mag) * DIV_W'(BPS_SCALE);
    thr_ext = (DIV_W + 1)'(sig_threshold);
    over = {1'b0, drsp.quotient} > thr_ext;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_threshold <= '0;
      order_quantity <= '0;
      lookback_ticks <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: sig_threshold <= cfg_data[THR_W-1:0];
        REG_QUANTITY: order_quantity <= cfg_data[QTY_W-1:0];
        REG_LOOKBACK: lookback_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      write_pointer <= '0;
      sample_count <= '0;
      position_held <= 1'b0;
      next_identifier <= ID_W'(1);
      m_tvalid <= 1'b0;
      dreq_start <= 1'b0;
    end else begin
      dreq_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_tuser[0] == CMD_TRADE) begin
              if (s_tuser[1]) begin
                position_held <= 1'b0;
              end
            end else if (ring_we) begin
              write_pointer <= write_pointer + 1'b1;
              if (sample_count != CNT_W'(RING_DEPTH)) begin
                sample_count <= sample_count + 1'b1;
              end
              mid <= in_price;
              oldest <= (in_time > TIME_W'(lookback_ticks)) ?
                        in_time - TIME_W'(lookback_ticks) : '0;
              walk_i <= '0;
              best <= '0;
              if (!position_held && sample_count != '0) begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: state <= S_WALK;
        S_WALK: begin
          if (rd_time < oldest) begin
            state <= S_DIV;
            dreq_start <= 1'b1;
          end else begin
            best <= rd_price;
            walk_i <= walk_i + 1'b1;
            if (walk_i + 1'b1 == sample_count) begin
              state <= S_DIV;
              dreq_start <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_DIV: begin
          if (dreq_start) begin
            neg <= mid < best;
          end
          if (drsp.done) begin
            state <= S_IDLE;
            if (over) begin
              m_tvalid <= 1'b1;
              m_tuser <= neg ? SIDE_SELL : SIDE_BUY;
              m_tdata <= {next_identifier, order_quantity};
              next_identifier <= next_identifier + 1'b1;
              position_held <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider operands come from the captured reference
  assign dreq = {dreq_start, scaled, best};

endmodule

// ===== src/mts_ram.sv =====
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mts_divider.sv =====
module mts_divider import mts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] quo;
  logic [PRICE_W:0] rem;
  logic [PRICE_W-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic [PRICE_W:0] trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem[PRICE_W-1:0], quo[DIV_W-1]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        cnt <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        if (!trial[PRICE_W]) begin
          rem <= trial;
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= {rem[PRICE_W-1:0], quo[DIV_W-1]};
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo};

endmodule
